### rtl/core/lecture_partition_dp_macros.svh
// Assertion macros used by the lecture partition checker.
`ifndef LECTURE_PARTITION_DP_MACROS_SVH
`define LECTURE_PARTITION_DP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define LPD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lecture partition check failed");

// Next-cycle implication, ignored while reset is high.
`define LPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lecture partition check failed");

// Next-cycle implication that also holds across reset.
`define LPD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lecture partition check failed");

`endif

### rtl/core/lpd_pkg.sv
// Shared types and constants of the lecture partition block.
`timescale 1ns / 1ps
package lpd_pkg;
   localparam int LEN_W        = 10;
   localparam int COUNT_W      = 11;
   localparam int COST_OUT_W   = 31;
   localparam int SLACK_LIMIT  = 10;
   localparam int COUNT_MAX    = 2047;
   localparam longint COST_MAX = 64'd1073741823;

   localparam logic [LEN_W-1:0] LENGTH_RESET  = 10'd500;
   localparam logic [LEN_W-1:0] PENALTY_RESET = 10'd10;

   localparam logic CSR_LECTURE_LENGTH = 1'b0;
   localparam logic CSR_SHORT_SLACK    = 1'b1;

   typedef enum logic [11:0] {
      S_LOAD     = 12'b0000_0000_0001,
      S_CHECK    = 12'b0000_0000_0010,
      S_G_RD     = 12'b0000_0000_0100,
      S_G_ACC    = 12'b0000_0000_1000,
      S_INIT     = 12'b0000_0001_0000,
      S_ROW      = 12'b0000_0010_0000,
      S_STEP_RD  = 12'b0000_0100_0000,
      S_STEP_ACC = 12'b0000_1000_0000,
      S_STEP_CMP = 12'b0001_0000_0000,
      S_WRITE    = 12'b0010_0000_0000,
      S_FINAL_RD = 12'b0100_0000_0000,
      S_REPORT   = 12'b1000_0000_0000
   } state_type;
endpackage

### rtl/core/lpd_if.sv
// Handshake channel interfaces for topics in and results out.
`timescale 1ns / 1ps
interface lpd_req_if import lpd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] topic_length;
   logic             last_topic;
   modport source(output valid, topic_length, last_topic, input ready);
   modport sink(input valid, topic_length, last_topic, output ready);
endinterface

interface lpd_rsp_if import lpd_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [COUNT_W-1:0]           lecture_count;
   logic signed [COST_OUT_W-1:0] total_dissatisfaction;
   logic                         error;
   modport source(output valid, lecture_count, total_dissatisfaction, error, input ready);
   modport sink(input valid, lecture_count, total_dissatisfaction, error, output ready);
endinterface

### rtl/core/lpd_topic_mem.sv
// Topic length store: one write port, one registered read port.
`timescale 1ns / 1ps
module lpd_topic_mem import lpd_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [LEN_W-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [LEN_W-1:0] rdata
);
   logic [LEN_W-1:0] mem [DEPTH];
   logic [LEN_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### rtl/core/lpd_cost_mem.sv
// Ping-pong DP row store: both rows in one array, bank bit on top of the address.
`timescale 1ns / 1ps
module lpd_cost_mem #(
   parameter int AW = 12,
   parameter int DW = 35
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);
   logic [DW-1:0] mem [1 << AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### rtl/core/lpd_engine.sv
// Sequencer: loads topics, runs the greedy count and the row-by-row DP.
`timescale 1ns / 1ps
module lpd_engine import lpd_pkg::*; #(
   parameter int MAX_TOPICS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [LEN_W-1:0]             lecture_length,
   input  logic [LEN_W-1:0]             short_slack_penalty,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [LEN_W-1:0]             req_topic_length,
   input  logic                         req_last_topic,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [COUNT_W-1:0]           rsp_lecture_count,
   output logic signed [COST_OUT_W-1:0] rsp_total_dissatisfaction,
   output logic                         rsp_error
);
   localparam int TW     = $clog2(MAX_TOPICS + 1);
   localparam int TAW    = $clog2(MAX_TOPICS);
   localparam int CW_RAW = TW + 23;
   localparam int CW     = (CW_RAW < 32) ? 32 : CW_RAW;
   localparam int DW     = CW + 1;
   localparam int SQ_W   = 2 * LEN_W;

   state_type state_ff, state_in;
   logic [TW-1:0]           total_ff, total_in;
   logic                    err_seen_ff, err_seen_in;
   logic                    err_ff, err_in;
   logic [LEN_W-1:0]        max_len_ff, max_len_in;
   logic [TW-1:0]           idx_ff, idx_in;
   logic [TW-1:0]           j_ff, j_in;
   logic [TW-1:0]           k_ff, k_in;
   logic [TW-1:0]           tally_ff, tally_in;
   logic [LEN_W:0]          fill_ff, fill_in;
   logic                    bank_ff, bank_in;
   logic signed [CW-1:0]    best_ff, best_in;
   logic                    have_ff, have_in;
   logic signed [CW-1:0]    sc_ff, sc_in;
   logic                    sc_ok_ff, sc_ok_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [COST_OUT_W-1:0]   rsp_cost_ff, rsp_cost_in;
   logic                    rsp_err_ff, rsp_err_in;

   logic                    t_we, t_re;
   logic [TAW-1:0]          t_waddr, t_raddr;
   logic [LEN_W-1:0]        t_rdata;
   logic                    c_we, c_re;
   logic [TW:0]             c_waddr, c_raddr;
   logic [DW-1:0]           c_wdata, c_rdata;

   logic                    accept;
   logic [LEN_W:0]          sum;
   logic [LEN_W-1:0]        slack, excess;
   logic [SQ_W-1:0]         square;
   logic signed [CW-1:0]    prev_cost, cand, final_cost;
   logic [TW-1:0]           count;
   logic                    out_free;

   lpd_topic_mem #(.DEPTH(MAX_TOPICS), .AW(TAW)) u_topic_mem (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(req_topic_length),
      .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
   );

   lpd_cost_mem #(.AW(TW + 1), .DW(DW)) u_cost_mem (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
      .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
   );

   assign req_ready = (state_ff == S_LOAD);
   assign accept    = req_valid && req_ready;
   assign sum       = fill_ff + {1'b0, t_rdata};
   assign slack     = lecture_length - sum[LEN_W-1:0];
   assign excess    = slack - LEN_W'(SLACK_LIMIT);
   assign square    = excess * excess;
   assign prev_cost = $signed(c_rdata[CW-1:0]);
   assign cand      = prev_cost + sc_ff;
   assign count     = tally_ff + TW'(1);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign final_cost = c_rdata[CW] ? prev_cost : '0;

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      err_seen_in  = err_seen_ff;
      err_in       = err_ff;
      max_len_in   = max_len_ff;
      idx_in       = idx_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      tally_in     = tally_ff;
      fill_in      = fill_ff;
      bank_in      = bank_ff;
      best_in      = best_ff;
      have_in      = have_ff;
      sc_in        = sc_ff;
      sc_ok_in     = sc_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_err_in   = rsp_err_ff;
      t_we         = 1'b0;
      t_waddr      = total_ff[TAW-1:0];
      t_re         = 1'b0;
      t_raddr      = idx_ff[TAW-1:0];
      c_we         = 1'b0;
      c_waddr      = {bank_ff, idx_ff};
      c_wdata      = '0;
      c_re         = 1'b0;
      c_raddr      = {bank_ff, idx_ff - TW'(1)};

      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (total_ff < TW'(MAX_TOPICS)) begin
                  t_we     = 1'b1;
                  total_in = total_ff + TW'(1);
                  if (req_topic_length > max_len_ff) begin
                     max_len_in = req_topic_length;
                  end
               end else begin
                  err_seen_in = 1'b1;
               end
               if (req_last_topic) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            idx_in   = '0;
            tally_in = '0;
            fill_in  = '0;
            if (err_seen_ff || (max_len_ff > lecture_length)) begin
               err_in   = 1'b1;
               state_in = S_REPORT;
            end else begin
               err_in   = 1'b0;
               state_in = S_G_RD;
            end
         end
         S_G_RD: begin
            if (idx_ff == total_ff) begin
               idx_in   = '0;
               state_in = S_INIT;
            end else begin
               t_re     = 1'b1;
               state_in = S_G_ACC;
            end
         end
         S_G_ACC: begin
            if (sum > {1'b0, lecture_length}) begin
               tally_in = tally_ff + TW'(1);
               fill_in  = {1'b0, t_rdata};
            end else begin
               fill_in = sum;
            end
            idx_in   = idx_ff + TW'(1);
            state_in = S_G_RD;
         end
         S_INIT: begin
            // seed the previous row: only the empty prefix is reachable
            c_we    = 1'b1;
            c_wdata = {(idx_ff == '0), CW'(0)};
            if (idx_ff == total_ff) begin
               j_in     = '0;
               k_in     = '0;
               state_in = S_ROW;
            end else begin
               idx_in = idx_ff + TW'(1);
            end
         end
         S_ROW: begin
            fill_in  = '0;
            have_in  = 1'b0;
            best_in  = '0;
            idx_in   = j_ff;
            state_in = S_STEP_RD;
         end
         S_STEP_RD: begin
            if (idx_ff == '0) begin
               state_in = S_WRITE;
            end else begin
               t_re     = 1'b1;
               t_raddr  = TAW'(idx_ff - TW'(1));
               c_re     = 1'b1;
               state_in = S_STEP_ACC;
            end
         end
         S_STEP_ACC: begin
            if (sum > {1'b0, lecture_length}) begin
               state_in = S_WRITE;
            end else begin
               fill_in  = sum;
               sc_ok_in = c_rdata[CW];
               if (slack == '0) begin
                  sc_in = '0;
               end else if (slack <= LEN_W'(SLACK_LIMIT)) begin
                  sc_in = -$signed(CW'(short_slack_penalty));
               end else begin
                  sc_in = $signed(CW'(square));
               end
               state_in = S_STEP_CMP;
            end
         end
         S_STEP_CMP: begin
            if (sc_ok_ff && (!have_ff || (cand < best_ff))) begin
               best_in = cand;
               have_in = 1'b1;
            end
            idx_in   = idx_ff - TW'(1);
            state_in = S_STEP_RD;
         end
         S_WRITE: begin
            c_we    = 1'b1;
            c_waddr = {!bank_ff, j_ff};
            c_wdata = {have_ff, best_ff};
            if (j_ff == total_ff) begin
               // row done: the new row becomes the previous one
               bank_in = !bank_ff;
               k_in    = k_ff + TW'(1);
               j_in    = '0;
               if (k_ff + TW'(1) == count) begin
                  state_in = S_FINAL_RD;
               end else begin
                  state_in = S_ROW;
               end
            end else begin
               j_in     = j_ff + TW'(1);
               state_in = S_ROW;
            end
         end
         S_FINAL_RD: begin
            c_re     = 1'b1;
            c_raddr  = {bank_ff, total_ff};
            state_in = S_REPORT;
         end
         S_REPORT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               if (err_ff) begin
                  rsp_count_in = '0;
                  rsp_cost_in  = '0;
               end else begin
                  if (32'(count) > 32'(COUNT_MAX)) begin
                     rsp_count_in = COUNT_W'(COUNT_MAX);
                  end else begin
                     rsp_count_in = COUNT_W'(count);
                  end
                  if (final_cost > $signed(CW'(COST_MAX))) begin
                     rsp_cost_in = COST_OUT_W'(COST_MAX);
                  end else begin
                     rsp_cost_in = final_cost[COST_OUT_W-1:0];
                  end
               end
               total_in    = '0;
               err_seen_in = 1'b0;
               max_len_in  = '0;
               state_in    = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         total_ff     <= '0;
         err_seen_ff  <= 1'b0;
         max_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         bank_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         err_seen_ff  <= err_seen_in;
         max_len_ff   <= max_len_in;
         rsp_valid_ff <= rsp_valid_in;
         bank_ff      <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      idx_ff       <= idx_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      tally_ff     <= tally_in;
      fill_ff      <= fill_in;
      best_ff      <= best_in;
      have_ff      <= have_in;
      sc_ff        <= sc_in;
      sc_ok_ff     <= sc_ok_in;
      rsp_count_ff <= rsp_count_in;
      rsp_cost_ff  <= rsp_cost_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_lecture_count         = rsp_count_ff;
   assign rsp_total_dissatisfaction = $signed(rsp_cost_ff);
   assign rsp_error                 = rsp_err_ff;
endmodule

### rtl/core/lecture_partition_dp.sv
// Top level of the lecture partition block: CSRs, channels and the DP engine.
//   channel | dir | carries
//   req     | in  | topic_length, last_topic
//   rsp     | out | lecture_count, total_dissatisfaction, error
//   csr     | in  | csr_we, csr_index, csr_wdata (write only)
// Topics are stored as they are accepted; the closing topic starts the computation.
// With n topics and K lectures: a check, the greedy count over the topics, a
// seed of the n+1 entries of row zero, then K rows of n+1 entries, each one
// scanning back over topics until one overflows the lecture, all set by the
// single read port of the topic and cost row memories; then the report.
// Reset is synchronous; the result waits in an output register under stall.
`timescale 1ns / 1ps
module lecture_partition_dp import lpd_pkg::*; #(
   parameter int MAX_TOPICS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   lpd_req_if.sink          req_port,
   lpd_rsp_if.source        rsp_port,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [LEN_W-1:0] csr_wdata
);
   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] penalty_ff, penalty_in;

   always_comb begin
      length_in  = length_ff;
      penalty_in = penalty_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LECTURE_LENGTH: length_in  = csr_wdata;
            CSR_SHORT_SLACK:    penalty_in = csr_wdata;
            default:            length_in  = length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff  <= LENGTH_RESET;
         penalty_ff <= PENALTY_RESET;
      end else begin
         length_ff  <= length_in;
         penalty_ff <= penalty_in;
      end
   end

   lpd_engine #(.MAX_TOPICS(MAX_TOPICS)) u_engine (
      .clock                    (clock),
      .reset                    (reset),
      .lecture_length           (length_ff),
      .short_slack_penalty      (penalty_ff),
      .req_valid                (req_port.valid),
      .req_ready                (req_port.ready),
      .req_topic_length         (req_port.topic_length),
      .req_last_topic           (req_port.last_topic),
      .rsp_valid                (rsp_port.valid),
      .rsp_ready                (rsp_port.ready),
      .rsp_lecture_count        (rsp_port.lecture_count),
      .rsp_total_dissatisfaction(rsp_port.total_dissatisfaction),
      .rsp_error                (rsp_port.error)
   );
endmodule

### rtl/core/lpd_checker.sv
// Port-level checks on the lecture partition block, bound to the top level.
`timescale 1ns / 1ps
`include "lecture_partition_dp_macros.svh"
module lpd_checker import lpd_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_last_topic,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [COUNT_W-1:0]           rsp_lecture_count,
   input logic signed [COST_OUT_W-1:0] rsp_total_dissatisfaction,
   input logic                         rsp_error
);
   `LPD_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid && req_ready)
   `LPD_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `LPD_ASSERT_IMPL(a_error_zero, clock, reset, rsp_valid && rsp_error,
                    rsp_lecture_count == '0 && rsp_total_dissatisfaction == '0)
   `LPD_ASSERT_IMPL(a_count_nonzero, clock, reset, rsp_valid && !rsp_error,
                    rsp_lecture_count != '0)
   `LPD_ASSERT_NEXT(a_close_waits, clock, reset, req_valid && req_ready && req_last_topic,
                    !req_ready)
endmodule

bind lecture_partition_dp lpd_checker u_lpd_checker (
   .clock                    (clock),
   .reset                    (reset),
   .req_valid                (req_port.valid),
   .req_ready                (req_port.ready),
   .req_last_topic           (req_port.last_topic),
   .rsp_valid                (rsp_port.valid),
   .rsp_ready                (rsp_port.ready),
   .rsp_lecture_count        (rsp_port.lecture_count),
   .rsp_total_dissatisfaction(rsp_port.total_dissatisfaction),
   .rsp_error                (rsp_port.error)
);

### tb/sv/lecture_partition_dp_test.sv
// Testbench for lecture_partition_dp: directed table, an oversized set, then random topic sets.
`timescale 1ns / 1ps
module lecture_partition_dp_test;
   import lpd_pkg::*;

   localparam int TOPIC_CAP   = 1024;
   localparam int CYCLE_LIMIT = 8000000;
   localparam int RANDOM_ITEMS = 120;
   localparam int NUM_PHASES  = 8;

   typedef struct packed {
      logic [COUNT_W-1:0]           count;
      logic signed [COST_OUT_W-1:0] cost;
      logic                         err;
   } plan_t;

   typedef struct {
      logic [LEN_W-1:0] len;
      logic             last;
      logic             typed;
      plan_t            plan;
   } row_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [LEN_W-1:0] csr_wdata;

   lpd_req_if req_ch();
   lpd_rsp_if rsp_ch();

   lecture_partition_dp #(.MAX_TOPICS(TOPIC_CAP)) dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_ch.sink),
      .rsp_port(rsp_ch.source),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // predictor state
   int unsigned lec_len;
   int unsigned slack_pen;
   int unsigned loaded_topics[$];
   bit          overflow_seen;
   plan_t       plans_waiting[$];

   int  mismatches;
   int  results_seen;
   int  error_results;
   int  items_sent;
   int  cycles;
   bit  send_gaps;
   bit  rsp_stalls;

   row_t directed[$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, plans_waiting.size());
         $display("lecture_partition_dp_test NOT OK");
         $finish;
      end
   end

   function automatic longint slack_price(int unsigned slack);
      if (slack == 0)
         return 0;
      if (slack <= SLACK_LIMIT)
         return -longint'(slack_pen);
      return longint'(slack - SLACK_LIMIT) * longint'(slack - SLACK_LIMIT);
   endfunction

   // Work out the fewest lectures and the least dissatisfaction of the set.
   function automatic plan_t plan_lectures();
      plan_t  p;
      int     n;
      bit     err;
      int unsigned tally, fill, lectures;
      longint prev_cost[], cur_cost[];
      bit     prev_ok[], cur_ok[];
      longint best, cand, total;
      bit     have;
      n = loaded_topics.size();
      err = overflow_seen;
      foreach (loaded_topics[i])
         if (loaded_topics[i] > lec_len)
            err = 1'b1;
      p = '0;
      if (err) begin
         p.err = 1'b1;
         return p;
      end
      tally = 0;
      fill = 0;
      foreach (loaded_topics[i]) begin
         fill += loaded_topics[i];
         if (fill > lec_len) begin
            tally++;
            fill = loaded_topics[i];
         end
      end
      lectures = tally + 1;
      prev_cost = new[n + 1];
      cur_cost = new[n + 1];
      prev_ok = new[n + 1];
      cur_ok = new[n + 1];
      for (int j = 0; j <= n; j++)
         prev_ok[j] = 1'b0;
      prev_cost[0] = 0;
      prev_ok[0] = 1'b1;
      for (int k = 1; k <= lectures; k++) begin
         for (int j = 0; j <= n; j++) begin
            fill = 0;
            have = 1'b0;
            best = 0;
            for (int i = j; i > 0; i--) begin
               fill += loaded_topics[i - 1];
               if (fill > lec_len)
                  break;
               if (prev_ok[i - 1]) begin
                  cand = prev_cost[i - 1] + slack_price(lec_len - fill);
                  if (!have || cand < best) begin
                     best = cand;
                     have = 1'b1;
                  end
               end
            end
            cur_cost[j] = best;
            cur_ok[j] = have;
         end
         prev_cost = cur_cost;
         prev_ok = cur_ok;
      end
      total = prev_ok[n] ? prev_cost[n] : 0;
      if (total > COST_MAX)
         total = COST_MAX;
      if (lectures > COUNT_MAX)
         lectures = COUNT_MAX;
      p.count = lectures[COUNT_W-1:0];
      p.cost = total[COST_OUT_W-1:0];
      return p;
   endfunction

   // Book one accepted topic; on the closing topic queue the expected result.
   task automatic book_topic(input int unsigned len, input bit last, input bit typed,
                             input plan_t typed_plan);
      plan_t expected;
      if (loaded_topics.size() < TOPIC_CAP)
         loaded_topics = {loaded_topics, len};
      else
         overflow_seen = 1'b1;
      if (last) begin
         expected = typed ? typed_plan : plan_lectures();
         plans_waiting = {plans_waiting, expected};
         loaded_topics.delete();
         overflow_seen = 1'b0;
      end
   endtask

   task automatic send_topic(input int unsigned len, input bit last, input bit typed,
                             input plan_t typed_plan);
      int gap;
      gap = send_gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.topic_length <= len[LEN_W-1:0];
      req_ch.last_topic <= last;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      book_topic(len, last, typed, typed_plan);
   endtask

   // Hold the sender until every result is in, then let the engine settle.
   task automatic drain();
      if (req_ch.valid)
         req_ch.valid <= 1'b0;
      while (plans_waiting.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input int unsigned value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[LEN_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LECTURE_LENGTH)
         lec_len = value;
      else
         slack_pen = value;
   endtask

   function automatic int unsigned pick_length(bit noisy);
      if (noisy)
         return $urandom_range(0, 1023);
      case ($urandom_range(0, 7))
         0: return 0;
         1: return lec_len;
         2: return (lec_len > 10) ? $urandom_range(lec_len - 10, lec_len) : lec_len;
         default: return $urandom_range(0, lec_len);
      endcase
   endfunction

   function automatic void add_row(int unsigned len, bit last, bit typed,
                                   int unsigned count, int cost, bit err);
      row_t r;
      r.len = len[LEN_W-1:0];
      r.last = last;
      r.typed = typed;
      r.plan.count = count[COUNT_W-1:0];
      r.plan.cost = cost[COST_OUT_W-1:0];
      r.plan.err = err;
      directed = {directed, r};
   endfunction

   // result side: random stalls, compare with the oldest expectation
   initial begin
      plan_t want;
      int stall;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      forever begin
         stall = rsp_stalls ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         results_seen++;
         if (rsp_ch.error)
            error_results++;
         if (plans_waiting.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: count %0d cost %0d error %0b",
                        rsp_ch.lecture_count, rsp_ch.total_dissatisfaction, rsp_ch.error);
         end else begin
            want = plans_waiting.pop_front();
            if (rsp_ch.lecture_count !== want.count ||
                rsp_ch.total_dissatisfaction !== want.cost || rsp_ch.error !== want.err) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected count %0d cost %0d error %0b, got %0d %0d %0b",
                           results_seen, want.count, want.cost, want.err,
                           rsp_ch.lecture_count, rsp_ch.total_dissatisfaction, rsp_ch.error);
            end
         end
      end
   end

   initial begin
      int unsigned lens[NUM_PHASES] = '{500, 1, 1023, 37, 700, 1023, 12, 333};
      int unsigned pens[NUM_PHASES] = '{10, 0, 1023, 5, 1023, 0, 777, 10};
      int unsigned n, per_phase, phase_items;
      bit noisy;
      plan_t none;
      none = '0;
      mismatches = 0;
      results_seen = 0;
      error_results = 0;
      items_sent = 0;
      overflow_seen = 1'b0;
      lec_len = LENGTH_RESET;
      slack_pen = PENALTY_RESET;
      send_gaps = 1'b1;
      rsp_stalls = 1'b1;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_LECTURE_LENGTH;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.topic_length = '0;
      req_ch.last_topic = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset values in force: L = 500, C = 10
      add_row(500, 1, 1, 1, 0, 0);
      add_row(490, 1, 1, 1, -10, 0);
      add_row(489, 1, 1, 1, 1, 0);
      add_row(501, 1, 1, 0, 0, 1);
      add_row(0, 1, 1, 1, 240100, 0);
      add_row(1023, 1, 1, 0, 0, 1);
      add_row(250, 0, 0, 0, 0, 0);
      add_row(250, 1, 1, 1, 0, 0);
      add_row(300, 0, 0, 0, 0, 0);
      add_row(300, 1, 1, 2, 72200, 0);
      add_row(1023, 0, 0, 0, 0, 0);
      add_row(5, 1, 1, 0, 0, 1);
      add_row(100, 0, 0, 0, 0, 0);
      add_row(200, 0, 0, 0, 0, 0);
      add_row(300, 0, 0, 0, 0, 0);
      add_row(400, 0, 0, 0, 0, 0);
      add_row(495, 1, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 0, 0);
      add_row(511, 0, 0, 0, 0, 0);
      add_row(250, 1, 0, 0, 0, 0);
      foreach (directed[i])
         send_topic(directed[i].len, directed[i].last, directed[i].typed, directed[i].plan);
      drain();

      // one set beyond the topic store, sent back to back
      send_gaps = 1'b0;
      for (int i = 0; i <= TOPIC_CAP; i++)
         send_topic($urandom_range(0, 1023), i == TOPIC_CAP, 1'b0, none);
      drain();

      per_phase = RANDOM_ITEMS / NUM_PHASES;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_csr(CSR_LECTURE_LENGTH, lens[ph]);
         write_csr(CSR_SHORT_SLACK, pens[ph]);
         send_gaps = (ph % 3) != 1;
         rsp_stalls = (ph % 4) != 2;
         phase_items = 0;
         while (phase_items < per_phase) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               noisy = $urandom_range(0, 29) == 0;
               send_topic(pick_length(noisy), i == n - 1, 1'b0, none);
            end
            phase_items += n;
         end
         drain();
      end

      $display("sent %0d topics over %0d register settings", items_sent, NUM_PHASES + 1);
      $display("checked %0d results, %0d of them rejected sets", results_seen, error_results);
      if (mismatches == 0 && plans_waiting.size() == 0) begin
         $display("lecture_partition_dp_test OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, plans_waiting.size());
         $display("lecture_partition_dp_test NOT OK");
      end
      $finish;
   end
endmodule

### lecture_partition_dp.f
+incdir+rtl/core
rtl/core/lpd_pkg.sv
rtl/core/lpd_if.sv
rtl/core/lpd_topic_mem.sv
rtl/core/lpd_cost_mem.sv
rtl/core/lpd_engine.sv
rtl/core/lecture_partition_dp.sv
rtl/core/lpd_checker.sv
tb/sv/lecture_partition_dp_test.sv
